// ----- rtl/ofmp_pkg.sv -----
// Shared types and constants for the order feed message parser.
package ofmp_pkg;

	localparam int unsigned HEADER_BYTES = 12;
	localparam int unsigned TIME_BYTES   = 8;

	// Type bytes of the message kinds.
	localparam logic [7:0] TYPE_NEW    = 8'h4E; // 'N'
	localparam logic [7:0] TYPE_CANCEL = 8'h43; // 'C'
	localparam logic [7:0] TYPE_TRADE  = 8'h54; // 'T'
	localparam logic [7:0] TYPE_MODIFY = 8'h4D; // 'M'
	localparam logic [7:0] TYPE_QUERY  = 8'h51; // 'Q'

	typedef enum logic [2:0] {
		K_HEADER = 3'd0,
		K_NEW    = 3'd1,
		K_CANCEL = 3'd2,
		K_TRADE  = 3'd3,
		K_MODIFY = 3'd4,
		K_QUERY  = 3'd5,
		K_ERROR  = 3'd6
	} kind_t;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_TYPE   = 4'b0010,
		PH_BODY   = 4'b0100,
		PH_HALT   = 4'b1000
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] packet_time;
		logic [31:0] message_count;
		logic [63:0] price;
		logic [63:0] quantity;
		logic [31:0] symbol_id;
		logic [63:0] order_id;
		logic [7:0]  side_code;
		logic        last;
	} rec_t;

	// Byte position of the final body byte of each message kind.
	function automatic logic [4:0] body_last_index(input kind_t kind);
		logic [4:0] idx;
		case (kind)
			K_NEW:    idx = 5'd28;
			K_CANCEL: idx = 5'd7;
			K_TRADE:  idx = 5'd7;
			K_MODIFY: idx = 5'd23;
			default:  idx = 5'd3;
		endcase
		return idx;
	endfunction

endpackage

// ----- rtl/ofmp_in_stage.sv -----
// Input register stage: holds one feed byte until the parser takes it.
module ofmp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

// ----- rtl/ofmp_core.sv -----
// Parser state, field shift registers and per-byte result decode.
module ofmp_core
	import ofmp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_s1,
	output logic       res_valid,
	output rec_t       res
);

	phase_t      phase_q, phase_d;
	logic [4:0]  idx_q, idx_d;
	kind_t       kind_q, kind_d;
	logic [31:0] left_q, left_d;
	logic [31:0] pcount_q, pcount_d;
	logic [63:0] time_q, time_d;
	logic [63:0] price_q, price_d;
	logic [63:0] qty_q, qty_d;
	logic [31:0] sym_q, sym_d;
	logic [63:0] order_q, order_d;
	logic [31:0] left_sh;
	logic        body_done;

	assign left_sh   = {byte_s1, left_q[31:8]};
	assign body_done = (idx_q == body_last_index(kind_q));

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		kind_d    = kind_q;
		left_d    = left_q;
		pcount_d  = pcount_q;
		time_d    = time_q;
		price_d   = price_q;
		qty_d     = qty_q;
		sym_d     = sym_q;
		order_d   = order_q;
		res_valid = 1'b0;
		res       = '0;
		res.packet_time   = time_q;
		res.message_count = pcount_q;
		if (step) begin
			case (phase_q)
				PH_HEADER: begin
					if (idx_q < 5'(TIME_BYTES)) begin
						time_d = {byte_s1, time_q[63:8]};
					end else begin
						left_d = left_sh;
					end
					if (idx_q == 5'(HEADER_BYTES - 1)) begin
						idx_d             = '0;
						pcount_d          = left_sh;
						phase_d           = (left_sh == '0) ? PH_HEADER : PH_TYPE;
						res_valid         = 1'b1;
						res.kind          = K_HEADER;
						res.message_count = left_sh;
						res.last          = (left_sh == '0);
					end else begin
						idx_d = idx_q + 5'd1;
					end
				end
				PH_TYPE: begin
					idx_d   = '0;
					phase_d = PH_BODY;
					case (byte_s1)
						TYPE_NEW:    kind_d = K_NEW;
						TYPE_CANCEL: kind_d = K_CANCEL;
						TYPE_TRADE:  kind_d = K_TRADE;
						TYPE_MODIFY: kind_d = K_MODIFY;
						TYPE_QUERY:  kind_d = K_QUERY;
						default: begin
							// unknown type: report once, then drop all bytes
							phase_d   = PH_HALT;
							res_valid = 1'b1;
							res.kind  = K_ERROR;
							res.last  = 1'b1;
						end
					endcase
				end
				PH_BODY: begin
					case (kind_q)
						K_NEW: begin
							if (idx_q < 5'd8) begin
								price_d = {byte_s1, price_q[63:8]};
							end else if (idx_q < 5'd16) begin
								qty_d = {byte_s1, qty_q[63:8]};
							end else if (idx_q < 5'd20) begin
								sym_d = {byte_s1, sym_q[31:8]};
							end else if (idx_q < 5'd28) begin
								order_d = {byte_s1, order_q[63:8]};
							end
						end
						K_MODIFY: begin
							if (idx_q < 5'd8) begin
								price_d = {byte_s1, price_q[63:8]};
							end else if (idx_q < 5'd16) begin
								qty_d = {byte_s1, qty_q[63:8]};
							end else begin
								order_d = {byte_s1, order_q[63:8]};
							end
						end
						K_CANCEL, K_TRADE: begin
							order_d = {byte_s1, order_q[63:8]};
						end
						default: begin
							sym_d = {byte_s1, sym_q[31:8]};
						end
					endcase
					if (body_done) begin
						idx_d     = '0;
						left_d    = left_q - 32'd1;
						phase_d   = (left_q == 32'd1) ? PH_HEADER : PH_TYPE;
						res_valid = 1'b1;
						res.last  = (left_q == 32'd1);
						case (kind_q)
							K_NEW: begin
								res.kind      = K_NEW;
								res.price     = price_d;
								res.quantity  = qty_d;
								res.symbol_id = sym_d;
								res.order_id  = order_d;
								res.side_code = byte_s1;
							end
							K_MODIFY: begin
								res.kind     = K_MODIFY;
								res.price    = price_d;
								res.quantity = qty_d;
								res.order_id = order_d;
							end
							K_CANCEL, K_TRADE: begin
								res.kind     = kind_q;
								res.order_id = order_d;
							end
							default: begin
								res.kind      = K_QUERY;
								res.symbol_id = sym_d;
							end
						endcase
					end else begin
						idx_d = idx_q + 5'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			idx_q    <= '0;
			kind_q   <= K_HEADER;
			left_q   <= '0;
			pcount_q <= '0;
		end else begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			kind_q   <= kind_d;
			left_q   <= left_d;
			pcount_q <= pcount_d;
		end
	end

	always_ff @(posedge clk) begin
		time_q  <= time_d;
		price_q <= price_d;
		qty_q   <= qty_d;
		sym_q   <= sym_d;
		order_q <= order_d;
	end

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |-> !res_valid)
		else $error("result produced while halted");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("parser left halt without reset");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 5'd28)
		else $error("byte index beyond longest body");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == K_ERROR |-> res.last && phase_d == PH_HALT)
		else $error("error result must end packet and halt");

	a_header_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == K_HEADER |-> res.last == (res.message_count == '0))
		else $error("header last flag disagrees with count");

endmodule

// ----- rtl/ofmp_out_reg.sv -----
// Result register: holds one parsed record until the sink takes it.
module ofmp_out_reg
	import ofmp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  rec_t rec_in,
	output logic free,
	output logic out_valid,
	input  logic out_ready,
	output rec_t rec_q
);

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			rec_q <= rec_in;
		end
	end

endmodule

// ----- rtl/order_feed_message_parser.sv -----
// Top level of the order feed message parser.
// Takes a market-feed stream one byte per word and emits one record per
// packet header (12 bytes: 8-byte timestamp, 4-byte message count, both
// little-endian) and one per complete message (type byte 'N', 'C', 'T',
// 'M' or 'Q' followed by its fixed little-endian body). Every record carries
// the current packet's timestamp and message count; fields a message kind
// does not have read as zero, and tlast marks the record that ends the
// packet (an empty packet's header, or its final message). An unknown type
// byte yields one error record with tlast set and the parser then drops
// every byte until reset. The block accepts one byte per cycle; the final
// byte of a message or header passes the input register and is then parsed
// into the result register, which holds the record until the sink takes it.
// The only thing that holds input back is a record waiting in the result
// register while the sink deasserts tready.
module order_feed_message_parser
	import ofmp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [63:0] packet_time, [95:64] message_count, [159:96] price,
	// [223:160] quantity, [255:224] symbol_id, [319:256] order_id,
	// [327:320] side_code
	output logic [327:0] m_axis_tdata,
	output logic         m_axis_tlast,  // last_of_packet
	output logic [2:0]   m_axis_tuser   // [2:0] record_kind
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       out_free;
	logic       res_valid;
	rec_t       res;
	rec_t       rec_q;

	// Advance a byte only when the result register can take whatever it yields.
	assign advance = valid_s1 && out_free;

	ofmp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	ofmp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ofmp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.rec_in    (res),
		.free      (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.rec_q     (rec_q)
	);

	// Pack the record, first field in the lowest bits.
	assign m_axis_tdata = {rec_q.side_code, rec_q.order_id, rec_q.symbol_id,
		rec_q.quantity, rec_q.price, rec_q.message_count, rec_q.packet_time};
	assign m_axis_tlast = rec_q.last;
	assign m_axis_tuser = rec_q.kind;

endmodule
